// ===== design/pfa_pkg.sv =====
// ----------------------------------------------------------------------------
// pfa_pkg: shared definitions for the partition fit allocator
// Table geometry, field widths, command codes, fit strategies and
// configuration register indexes.
// ----------------------------------------------------------------------------
package pfa_pkg;

   localparam int NUM_BLOCKS = 16;
   localparam int SIZE_BITS  = 16;

   localparam int INDEX_BITS = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int COUNT_BITS = $clog2(NUM_BLOCKS + 1);

   localparam int OPCODE_BITS    = 2;
   localparam int BLK_INDEX_BITS = 4;
   localparam int REQ_SIZE_BITS  = 16;
   localparam int BLK_NUM_BITS   = 4;

   localparam int STRATEGY_BITS  = 2;
   localparam int IN_USE_BITS    = 5;
   localparam int CSR_DATA_BITS  = 5;
   localparam int CSR_INDEX_BITS = 1;

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_LOAD  = 2'd0,
      OP_ALLOC = 2'd1,
      OP_FREE  = 2'd2
   } opcode_type;

   typedef enum logic [STRATEGY_BITS-1:0] {
      STRAT_FIRST = 2'd0,
      STRAT_BEST  = 2'd1,
      STRAT_WORST = 2'd2
   } strategy_type;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_STRATEGY      = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BLOCKS_IN_USE = 1'd1;

endpackage

// ===== design/partition_fit_allocator.sv =====
// ----------------------------------------------------------------------------
// partition_fit_allocator: fixed-partition allocator, first/best/worst fit
// Load and free beats answer one cycle after acceptance; busy stays low.
// An allocate beat holds busy while it scans N = blocks_in_use capped at 16
// size-table entries: one size-table read and compare per cycle, the taken mark at the
// end; its result beat appears in the same cycle that busy drops. Results cannot be
// stalled. Synchronous reset frees every block and clears strategy and
// blocks_in_use; the size table holds no value until loaded.
// ----------------------------------------------------------------------------
module partition_fit_allocator (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [pfa_pkg::OPCODE_BITS-1:0]       req_opcode,
   input  logic [pfa_pkg::BLK_INDEX_BITS-1:0]    req_block_index,
   input  logic [pfa_pkg::REQ_SIZE_BITS-1:0]     req_size_value,
   output logic                                  rsp_strobe,
   output logic                                  rsp_granted,
   output logic [pfa_pkg::BLK_NUM_BITS-1:0]      rsp_block_number,
   input  logic                                  csr_write_enable,
   input  logic [pfa_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [pfa_pkg::CSR_DATA_BITS-1:0]     csr_write_data
);

   import pfa_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type               state_ff, state_in;
   logic [COUNT_BITS-1:0]   addr_ff, addr_in;
   logic [COUNT_BITS-1:0]   limit_ff, limit_in;
   logic                    rd_valid_ff, rd_valid_in;
   logic [INDEX_BITS-1:0]   rd_idx_ff, rd_idx_in;
   logic                    found_ff, found_in;
   logic [INDEX_BITS-1:0]   pick_ff, pick_in;
   logic [SIZE_BITS-1:0]    best_ff, best_in;
   logic [SIZE_BITS-1:0]    request_ff, request_in;
   logic [NUM_BLOCKS-1:0]   taken_ff, taken_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   logic                    rsp_granted_ff, rsp_granted_in;
   logic [BLK_NUM_BITS-1:0] rsp_block_ff, rsp_block_in;

   logic [STRATEGY_BITS-1:0] strategy_ff;
   logic [IN_USE_BITS-1:0]   in_use_ff;

   logic                  accept;
   logic                  issue;
   logic                  ram_wr_en;
   logic [SIZE_BITS-1:0]  ram_rd_data;
   logic [COUNT_BITS-1:0] limit_cfg;
   logic                  fits;
   logic                  better;
   logic                  found_nx;
   logic [INDEX_BITS-1:0] pick_nx;
   logic [SIZE_BITS-1:0]  best_nx;

   pfa_ram #(
      .WIDTH (SIZE_BITS),
      .DEPTH (NUM_BLOCKS)
   ) u_size_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (INDEX_BITS'(req_block_index)),
      .wr_data (SIZE_BITS'(req_size_value)),
      .rd_en   (issue),
      .rd_addr (addr_ff[INDEX_BITS-1:0]),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         strategy_ff <= '0;
         in_use_ff   <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_STRATEGY:      strategy_ff <= csr_write_data[STRATEGY_BITS-1:0];
            CSR_BLOCKS_IN_USE: in_use_ff   <= csr_write_data[IN_USE_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign accept = start & ~busy;
   assign issue  = (state_ff == ST_SCAN) && (addr_ff < limit_ff);

   always_comb begin
      if (32'(in_use_ff) > NUM_BLOCKS) begin
         limit_cfg = COUNT_BITS'(NUM_BLOCKS);
      end else begin
         limit_cfg = COUNT_BITS'(in_use_ff);
      end
   end

   always_comb begin
      fits   = rd_valid_ff && !taken_ff[rd_idx_ff] && (ram_rd_data >= request_ff);
      better = !found_ff
               || ((strategy_ff == STRAT_BEST)  && (ram_rd_data < best_ff))
               || ((strategy_ff == STRAT_WORST) && (ram_rd_data > best_ff));
      if (fits && better) begin
         found_nx = 1'b1;
         pick_nx  = rd_idx_ff;
         best_nx  = ram_rd_data;
      end else begin
         found_nx = found_ff;
         pick_nx  = pick_ff;
         best_nx  = best_ff;
      end
   end

   always_comb begin
      state_in       = state_ff;
      addr_in        = addr_ff;
      limit_in       = limit_ff;
      rd_valid_in    = 1'b0;
      rd_idx_in      = rd_idx_ff;
      found_in       = found_ff;
      pick_in        = pick_ff;
      best_in        = best_ff;
      request_in     = request_ff;
      taken_in       = taken_ff;
      rsp_strobe_in  = 1'b0;
      rsp_granted_in = 1'b0;
      rsp_block_in   = '0;
      ram_wr_en      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  OP_LOAD: begin
                     ram_wr_en     = 32'(req_block_index) < NUM_BLOCKS;
                     rsp_strobe_in = 1'b1;
                  end
                  OP_ALLOC: begin
                     state_in   = ST_SCAN;
                     addr_in    = '0;
                     limit_in   = limit_cfg;
                     found_in   = 1'b0;
                     pick_in    = '0;
                     best_in    = '0;
                     request_in = SIZE_BITS'(req_size_value);
                  end
                  OP_FREE: begin
                     taken_in      = '0;
                     rsp_strobe_in = 1'b1;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            rd_valid_in = issue;
            rd_idx_in   = addr_ff[INDEX_BITS-1:0];
            found_in    = found_nx;
            pick_in     = pick_nx;
            best_in     = best_nx;
            if (issue) begin
               addr_in = COUNT_BITS'(addr_ff + 1'b1);
            end else begin
               state_in       = ST_IDLE;
               rsp_strobe_in  = 1'b1;
               rsp_granted_in = found_nx;
               if (found_nx) begin
                  rsp_block_in      = BLK_NUM_BITS'(pick_nx);
                  taken_in[pick_nx] = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         addr_ff        <= '0;
         limit_ff       <= '0;
         rd_valid_ff    <= 1'b0;
         rd_idx_ff      <= '0;
         found_ff       <= 1'b0;
         pick_ff        <= '0;
         taken_ff       <= '0;
         rsp_strobe_ff  <= 1'b0;
         rsp_granted_ff <= 1'b0;
         rsp_block_ff   <= '0;
      end else begin
         state_ff       <= state_in;
         addr_ff        <= addr_in;
         limit_ff       <= limit_in;
         rd_valid_ff    <= rd_valid_in;
         rd_idx_ff      <= rd_idx_in;
         found_ff       <= found_in;
         pick_ff        <= pick_in;
         taken_ff       <= taken_in;
         rsp_strobe_ff  <= rsp_strobe_in;
         rsp_granted_ff <= rsp_granted_in;
         rsp_block_ff   <= rsp_block_in;
      end
      best_ff    <= best_in;
      request_ff <= request_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_granted      = rsp_granted_ff;
   assign rsp_block_number = rsp_block_ff;

endmodule

// ===== design/pfa_ram.sv =====
// ----------------------------------------------------------------------------
// pfa_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data registered.
// ----------------------------------------------------------------------------
module pfa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
